/* rtl/drfp_pkg.sv */
package drfp_pkg;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_STR  = 2'd1;
    localparam logic [1:0] MODE_INT  = 2'd2;

    localparam logic [7:0] BYTE_START_STR = 8'h70;
    localparam logic [7:0] BYTE_START_INT = 8'h71;
    localparam logic [7:0] BYTE_TERM      = 8'hff;
    localparam logic [15:0] TERM_PAIR     = 16'hffff;

    localparam int LEN_W = 6;
    localparam int IDX_W = 5;

    localparam logic [LEN_W-1:0] INT_FRAME_COUNT = 6'd6;
    localparam logic [LEN_W-1:0] INT_LENGTH      = 6'd4;
    localparam logic [LEN_W-1:0] TERM_KEPT       = 6'd2;
    localparam logic [LEN_W-1:0] MAX_RESULTS     = 6'd32;
    localparam logic [LEN_W-1:0] INT_LAST_IDX    = 6'd3;

    localparam logic KIND_STR = 1'b0;
    localparam logic KIND_INT = 1'b1;

    typedef logic [7:0] byte_t;

endpackage

/* rtl/display_return_frame_parser.sv */
// Parses the bytes returned by a serial display. While idle, 0x70 opens a string frame and
// 0x71 an integer frame; other bytes are dropped. Frame bytes go into a buffer RAM of
// BUFFER_DEPTH entries (bytes beyond it are dropped and flag the frame as overflowed) until
// three 0xff in a row arrive; an integer frame ends only with exactly four data bytes before
// them. A string then comes out as a run of byte results ending in last (one result with
// length 0 for an empty string, at most 32 results), an integer as one little-endian 32-bit
// result. Input bytes are taken back to back while no readout runs. Readout goes through the
// single read port of the buffer RAM and holds off input: each byte is requested in an issue
// state and taken in a capture state, where a result waits out any output stall. The last
// result may wait in the output register while new bytes are taken.
module display_return_frame_parser #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        frame_kind,
    output logic [31:0] payload,
    output logic [4:0]  byte_index,
    output logic [5:0]  frame_length,
    output logic        last,
    output logic        overflowed
);

    localparam int AW    = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int LW    = drfp_pkg::LEN_W;

    localparam logic [1:0] ST_RUN     = 2'd0;
    localparam logic [1:0] ST_ISSUE   = 2'd1;
    localparam logic [1:0] ST_CAPTURE = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    logic [1:0]       st_reg, st_next;
    logic [1:0]       mode_reg, mode_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      recent_reg, recent_next;
    logic             ovf_reg, ovf_next;
    logic             kind_reg, kind_next;
    logic [LW-1:0]    len_reg, len_next;
    logic [LW-1:0]    n_reg, n_next;
    logic [LW-1:0]    idx_reg, idx_next;
    logic [31:0]      acc_reg, acc_next;

    logic             out_valid_reg, out_valid_next;
    logic             out_kind_reg, out_kind_next;
    logic [31:0]      out_payload_reg, out_payload_next;
    logic [4:0]       out_index_reg, out_index_next;
    logic [LW-1:0]    out_len_reg, out_len_next;
    logic             out_last_reg, out_last_next;
    logic             out_ovf_reg, out_ovf_next;

    logic             ram_we;
    logic             ram_re;
    drfp_pkg::byte_t  ram_rdata;

    logic             accept;
    logic             term;
    logic             out_free;
    logic [LW-1:0]    count_ext;
    logic [LW-1:0]    len_calc;
    logic [LW-1:0]    n_calc;

    drfp_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign in_ready  = (st_reg == ST_RUN);
    assign accept    = in_valid && in_ready;
    assign term      = (recent_reg == drfp_pkg::TERM_PAIR) && (rx_byte == drfp_pkg::BYTE_TERM);
    assign out_free  = !out_valid_reg || out_ready;
    assign ram_re    = (st_reg == ST_ISSUE);
    assign count_ext = LW'(count_reg);
    assign len_calc  = (count_ext >= drfp_pkg::TERM_KEPT) ? count_ext - drfp_pkg::TERM_KEPT
                                                          : '0;
    assign n_calc    = (len_calc > drfp_pkg::MAX_RESULTS) ? drfp_pkg::MAX_RESULTS : len_calc;

    always_comb
    begin
        st_next          = st_reg;
        mode_next        = mode_reg;
        count_next       = count_reg;
        recent_next      = recent_reg;
        ovf_next         = ovf_reg;
        kind_next        = kind_reg;
        len_next         = len_reg;
        n_next           = n_reg;
        idx_next         = idx_reg;
        acc_next         = acc_reg;
        ram_we           = 1'b0;
        out_valid_next   = out_valid_reg && !out_ready;
        out_kind_next    = out_kind_reg;
        out_payload_next = out_payload_reg;
        out_index_next   = out_index_reg;
        out_len_next     = out_len_reg;
        out_last_next    = out_last_reg;
        out_ovf_next     = out_ovf_reg;

        case (st_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    case (mode_reg)
                        drfp_pkg::MODE_IDLE:
                        begin
                            if (rx_byte == drfp_pkg::BYTE_START_STR ||
                                rx_byte == drfp_pkg::BYTE_START_INT)
                            begin
                                mode_next   = (rx_byte == drfp_pkg::BYTE_START_STR)
                                              ? drfp_pkg::MODE_STR : drfp_pkg::MODE_INT;
                                count_next  = '0;
                                recent_next = '0;
                                ovf_next    = 1'b0;
                            end
                        end
                        drfp_pkg::MODE_STR,
                        drfp_pkg::MODE_INT:
                        begin
                            if (term && mode_reg == drfp_pkg::MODE_STR)
                            begin
                                mode_next = drfp_pkg::MODE_IDLE;
                                kind_next = drfp_pkg::KIND_STR;
                                len_next  = len_calc;
                                n_next    = n_calc;
                                idx_next  = '0;
                                st_next   = (n_calc == '0) ? ST_EMPTY : ST_ISSUE;
                            end
                            else if (term && count_ext == drfp_pkg::INT_FRAME_COUNT)
                            begin
                                mode_next = drfp_pkg::MODE_IDLE;
                                kind_next = drfp_pkg::KIND_INT;
                                len_next  = drfp_pkg::INT_LENGTH;
                                idx_next  = '0;
                                st_next   = ST_ISSUE;
                            end
                            else
                            begin
                                // store the byte, or drop it once the buffer is full
                                if (count_reg < CNT_W'(BUFFER_DEPTH))
                                begin
                                    ram_we     = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                                recent_next = {recent_reg[7:0], rx_byte};
                            end
                        end
                        default:
                        begin
                            mode_next = drfp_pkg::MODE_IDLE;
                        end
                    endcase
                end
            end
            ST_ISSUE:
            begin
                st_next = ST_CAPTURE;
            end
            ST_CAPTURE:
            begin
                if (kind_reg == drfp_pkg::KIND_STR)
                begin
                    if (out_free)
                    begin
                        out_valid_next   = 1'b1;
                        out_kind_next    = drfp_pkg::KIND_STR;
                        out_payload_next = 32'(ram_rdata);
                        out_index_next   = idx_reg[4:0];
                        out_len_next     = len_reg;
                        out_last_next    = (idx_reg == n_reg - 1'b1);
                        out_ovf_next     = ovf_reg;
                        idx_next         = idx_reg + 1'b1;
                        st_next          = (idx_reg == n_reg - 1'b1) ? ST_RUN : ST_ISSUE;
                    end
                end
                else if (idx_reg == drfp_pkg::INT_LAST_IDX)
                begin
                    if (out_free)
                    begin
                        out_valid_next   = 1'b1;
                        out_kind_next    = drfp_pkg::KIND_INT;
                        out_payload_next = {ram_rdata, acc_reg[31:8]};
                        out_index_next   = '0;
                        out_len_next     = len_reg;
                        out_last_next    = 1'b1;
                        out_ovf_next     = ovf_reg;
                        st_next          = ST_RUN;
                    end
                end
                else
                begin
                    // little-endian assembly, newest byte on top
                    acc_next = {ram_rdata, acc_reg[31:8]};
                    idx_next = idx_reg + 1'b1;
                    st_next  = ST_ISSUE;
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_kind_next    = drfp_pkg::KIND_STR;
                    out_payload_next = '0;
                    out_index_next   = '0;
                    out_len_next     = len_reg;
                    out_last_next    = 1'b1;
                    out_ovf_next     = ovf_reg;
                    st_next          = ST_RUN;
                end
            end
            default:
            begin
                st_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_RUN;
            mode_reg      <= drfp_pkg::MODE_IDLE;
            count_reg     <= '0;
            recent_reg    <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            recent_reg    <= recent_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        len_reg         <= len_next;
        n_reg           <= n_next;
        acc_reg         <= acc_next;
        out_kind_reg    <= out_kind_next;
        out_payload_reg <= out_payload_next;
        out_index_reg   <= out_index_next;
        out_len_reg     <= out_len_next;
        out_last_reg    <= out_last_next;
        out_ovf_reg     <= out_ovf_next;
    end

    assign out_valid    = out_valid_reg;
    assign frame_kind   = out_kind_reg;
    assign payload      = out_payload_reg;
    assign byte_index   = out_index_reg;
    assign frame_length = out_len_reg;
    assign last         = out_last_reg;
    assign overflowed   = out_ovf_reg;

endmodule

/* rtl/drfp_ram.sv */
module drfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* verif/display_return_frame_parser_tb.sv */
`timescale 1ns / 100ps

module display_return_frame_parser_tb;

    localparam int BUF_DEPTH    = 32;
    localparam int RANDOM_ITEMS = 180;
    localparam int CALM_ITEMS   = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic [4:0]  idx;
        logic [5:0]  len;
        logic        last_flag;
        logic        ovf;
    } frame_result_t;

    class frame_checker;
        logic [1:0]      mode;
        drfp_pkg::byte_t stored [BUF_DEPTH];
        logic [5:0]      count;
        logic [15:0]     recent;
        logic            ovf;
        frame_result_t   expected_results [$];
        int              mismatches;
        int              results_seen;
        int              str_frames;
        int              int_frames;
        int              ovf_frames;

        function new();
            mode         = drfp_pkg::MODE_IDLE;
            count        = '0;
            recent       = '0;
            ovf          = 1'b0;
            mismatches   = 0;
            results_seen = 0;
            str_frames   = 0;
            int_frames   = 0;
            ovf_frames   = 0;
        endfunction

        function void open_frame(logic [1:0] m);
            mode   = m;
            count  = '0;
            recent = '0;
            ovf    = 1'b0;
        endfunction

        function void store_byte(drfp_pkg::byte_t b);
            if (count < BUF_DEPTH)
            begin
                stored[count] = b;
                count         = count + 1'b1;
            end
            else
                ovf = 1'b1;
            recent = {recent[7:0], b};
        endfunction

        function void add_result(logic kind, logic [31:0] value, logic [4:0] idx,
                                 logic [5:0] len, logic last_flag);
            frame_result_t r;
            r.kind      = kind;
            r.value     = value;
            r.idx       = idx;
            r.len       = len;
            r.last_flag = last_flag;
            r.ovf       = ovf;
            expected_results.push_back(r);
        endfunction

        // advance the parser by one received byte
        function void note_request(drfp_pkg::byte_t b);
            logic       term;
            logic [5:0] len;
            int         n;
            term = (recent == drfp_pkg::TERM_PAIR) && (b == drfp_pkg::BYTE_TERM);
            if (mode == drfp_pkg::MODE_IDLE)
            begin
                if (b == drfp_pkg::BYTE_START_STR)
                    open_frame(drfp_pkg::MODE_STR);
                else if (b == drfp_pkg::BYTE_START_INT)
                    open_frame(drfp_pkg::MODE_INT);
            end
            else if (mode == drfp_pkg::MODE_STR)
            begin
                if (term)
                begin
                    len  = (count >= drfp_pkg::TERM_KEPT) ? count - drfp_pkg::TERM_KEPT : '0;
                    n    = (len < drfp_pkg::MAX_RESULTS) ? int'(len)
                                                         : int'(drfp_pkg::MAX_RESULTS);
                    mode = drfp_pkg::MODE_IDLE;
                    str_frames++;
                    if (ovf)
                        ovf_frames++;
                    if (n == 0)
                        add_result(drfp_pkg::KIND_STR, '0, '0, len, 1'b1);
                    for (int i = 0; i < n; i++)
                        add_result(drfp_pkg::KIND_STR, {24'd0, stored[i]}, 5'(i), len,
                                   i == n - 1);
                end
                else
                    store_byte(b);
            end
            else if (mode == drfp_pkg::MODE_INT)
            begin
                if (term && count == drfp_pkg::INT_FRAME_COUNT)
                begin
                    mode = drfp_pkg::MODE_IDLE;
                    int_frames++;
                    add_result(drfp_pkg::KIND_INT,
                               {stored[3], stored[2], stored[1], stored[0]},
                               '0, drfp_pkg::INT_LENGTH, 1'b1);
                end
                else
                    store_byte(b);
            end
            else
                mode = drfp_pkg::MODE_IDLE;
        endfunction

        task report(string field, logic [31:0] got, logic [31:0] want);
            $display("mismatch at %0t on %s: got %0h, expected %0h", $realtime, field, got,
                     want);
            mismatches++;
        endtask

        task check_result(logic kind, logic [31:0] value, logic [4:0] idx, logic [5:0] len,
                          logic last_flag, logic ovf_in);
            frame_result_t want;
            results_seen++;
            if (expected_results.size() == 0)
            begin
                report("unexpected result", value, '0);
                return;
            end
            want = expected_results.pop_front();
            if (kind !== want.kind)
                report("frame_kind", kind, want.kind);
            if (value !== want.value)
                report("payload", value, want.value);
            if (idx !== want.idx)
                report("byte_index", idx, want.idx);
            if (len !== want.len)
                report("frame_length", len, want.len);
            if (last_flag !== want.last_flag)
                report("last", last_flag, want.last_flag);
            if (ovf_in !== want.ovf)
                report("overflowed", ovf_in, want.ovf);
        endtask

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic        frame_kind;
    logic [31:0] payload;
    logic [4:0]  byte_index;
    logic [5:0]  frame_length;
    logic        last;
    logic        overflowed;

    bit quiet;
    bit hold_req;
    int frame_items;
    int requests_sent;
    int cycle_count;

    frame_checker sb;

    display_return_frame_parser #(
        .BUFFER_DEPTH (BUF_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_kind   (frame_kind),
        .payload      (payload),
        .byte_index   (byte_index),
        .frame_length (frame_length),
        .last         (last),
        .overflowed   (overflowed)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     sb.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(frame_kind, payload, byte_index, frame_length, last, overflowed);
    end

    // result side: random stalls, plus one long hold when asked
    always
    begin
        int gap;
        @(negedge clk);
        if (hold_req)
        begin
            out_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_req = 1'b0;
        end
        else if (!quiet && $urandom_range(0, 4) == 0)
        begin
            out_ready <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap - 1) @(negedge clk);
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_byte(input drfp_pkg::byte_t b);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(b);
        requests_sent++;
    endtask

    task automatic send_term();
        repeat (3) send_byte(drfp_pkg::BYTE_TERM);
    endtask

    // frame content, biased toward 0xff and the start bytes
    function automatic drfp_pkg::byte_t random_content();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return drfp_pkg::BYTE_TERM;
        else if (pick == 2)
            return ($urandom_range(0, 1) == 0) ? drfp_pkg::BYTE_START_STR
                                               : drfp_pkg::BYTE_START_INT;
        return drfp_pkg::byte_t'($urandom_range(0, 255));
    endfunction

    // content never holds three 0xff in a row, so the frame cannot end inside its content
    task automatic send_string(input int n);
        int              ff_run;
        drfp_pkg::byte_t b;
        ff_run = 0;
        send_byte(drfp_pkg::BYTE_START_STR);
        for (int i = 0; i < n; i++)
        begin
            b = random_content();
            if (ff_run >= 2 && b == drfp_pkg::BYTE_TERM)
                b = drfp_pkg::byte_t'($urandom_range(0, 254));
            ff_run = (b == drfp_pkg::BYTE_TERM) ? ff_run + 1 : 0;
            send_byte(b);
        end
        send_term();
        frame_items += n + 4;
    endtask

    task automatic send_integer(input logic [31:0] v);
        send_byte(drfp_pkg::BYTE_START_INT);
        for (int i = 0; i < 4; i++)
            send_byte(v[8*i +: 8]);
        send_term();
        frame_items += 8;
    endtask

    function automatic int string_length();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return $urandom_range(31, 40);
        else if (pick < 4)
            return $urandom_range(9, 30);
        return $urandom_range(0, 8);
    endfunction

    function automatic drfp_pkg::byte_t noise_byte();
        drfp_pkg::byte_t b;
        b = drfp_pkg::byte_t'($urandom_range(0, 255));
        if (b == drfp_pkg::BYTE_START_STR || b == drfp_pkg::BYTE_START_INT)
            b = b ^ 8'h10;
        return b;
    endfunction

    initial
    begin
        int unsigned pick;
        sb        = new();
        in_valid  = 1'b0;
        rx_byte   = '0;
        out_ready = 1'b0;
        rst_n     = 1'b0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ignored bytes while idle
        send_byte(8'h00);
        send_byte(drfp_pkg::BYTE_TERM);
        // empty string
        send_byte(drfp_pkg::BYTE_START_STR);
        send_term();
        // start bytes and extremes as string content
        send_byte(drfp_pkg::BYTE_START_STR);
        send_byte(drfp_pkg::BYTE_START_INT);
        send_byte(drfp_pkg::BYTE_START_STR);
        send_byte(8'h00);
        send_byte(drfp_pkg::BYTE_TERM);
        send_term();
        send_integer(32'h0000_0000);
        send_integer(32'hffff_ffff);

        // output held off while a long overflowing string comes in
        frame_items = 0;
        hold_req    = 1'b1;
        send_string(36);
        send_integer($urandom);
        send_string($urandom_range(0, 8));

        while (frame_items < RANDOM_ITEMS)
        begin
            quiet = (frame_items > CALM_ITEMS);
            pick  = $urandom_range(0, 9);
            if (pick < 5)
                send_string(string_length());
            else if (pick < 8)
                send_integer({random_content(), random_content(), random_content(),
                              random_content()});
            else
                repeat ($urandom_range(1, 3)) send_byte(noise_byte());
        end

        // integer frame with too many data bytes: it never closes
        send_byte(drfp_pkg::BYTE_START_INT);
        repeat (5) send_byte(drfp_pkg::byte_t'($urandom_range(0, 254)));
        send_term();
        repeat (40) send_byte(drfp_pkg::byte_t'($urandom_range(0, 255)));

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d bytes: %0d string frames (%0d overflowed), %0d integer frames",
                 requests_sent, sb.str_frames, sb.ovf_frames, sb.int_frames);
        $display("checked %0d results, one long output hold, %0d mismatches",
                 sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
